/* src/mld_pkg.sv */
// ----------------------------------------------------------------------------
// mld_pkg
// Shared types and constants for the max-log soft demapper.
// ----------------------------------------------------------------------------
`default_nettype none

package mld_pkg;

    localparam int MAX_BITS_DEF     = 6;
    localparam int HALF_POINTS_DEF  = 32;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int NPTS      = 64;
    localparam int PIDX_W    = 6;
    localparam int LLR_W     = 24;
    localparam int OUT_SHIFT = 20;

    typedef enum logic [1:0] {
        OP_LOAD_POINT = 2'd0,
        OP_LOAD_PART  = 2'd1,
        OP_DEMAP      = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_NUM_POINTS = 2'd0,
        REG_BITS       = 2'd1,
        REG_INV_VAR    = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    // control broadcast to every cell at once, one beat per slot
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* src/max_log_llr_soft_demapper.sv */
// ----------------------------------------------------------------------------
// max_log_llr_soft_demapper
// Loads points and bit partitions, then sweeps all slots per sample with one
// cell per label bit and emits one LLR beat per bit.
// ----------------------------------------------------------------------------
//  channel  direction  handshake        payload
//  in       sink       in_valid/stall   opcode .. last_symbol
//  out      source     out_valid/stall  llr, bit_index, last_of_symbol/block
//  cfg      sink       cfg_valid/ready  cfg_index, cfg_data
//
//  Load beats complete on acceptance. A demap beat offers its first LLR once
//  its slots have passed, one slot a cycle, through the partition and point
//  memories, three stages to the cells, then difference, multiply and
//  saturate; then one LLR a cycle while out_stall is low. The next beat is
//  taken the cycle after the last LLR leaves.
//  Output stall simply holds the current LLR; no new sample is taken until
//  all LLRs of the previous one are gone. Reset needs no clearing pass.
`default_nettype none

module max_log_llr_soft_demapper #(
    parameter int MAX_BITS     = mld_pkg::MAX_BITS_DEF,
    parameter int HALF_POINTS  = mld_pkg::HALF_POINTS_DEF,
    parameter int SAMPLE_WIDTH = mld_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [5:0]                    point_index,
    input  wire logic signed [SAMPLE_WIDTH-1:0] point_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0] point_q,
    input  wire logic                          label_value,
    input  wire logic [2:0]                    bit_position,
    input  wire logic [4:0]                    slot,
    input  wire logic signed [SAMPLE_WIDTH-1:0] rx_i,
    input  wire logic signed [SAMPLE_WIDTH-1:0] rx_q,
    input  wire logic                          last_symbol,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [23:0]                 llr,
    output logic [2:0]                         bit_index,
    output logic                               last_of_symbol,
    output logic                               last_of_block,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import mld_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int DW  = 2 * (SW + 1) + 1;
    localparam int SLW = (HALF_POINTS > 1) ? $clog2(HALF_POINTS) : 1;
    localparam int CW  = SLW + 1;
    localparam int BW  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int BCW = $clog2(MAX_BITS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_EMIT} state_t;

    logic [6:0]  num_points_reg;
    logic [2:0]  bits_reg;
    logic [15:0] inv_var_reg;

    state_t state_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  nslot_reg;
    logic [BCW-1:0] nb_reg;
    logic [BCW-1:0] emit_reg;
    logic           last_reg;
    logic signed [SW-1:0] rxi_reg, rxq_reg;

    logic accept;
    logic [CW-1:0] slots_c;
    logic [BCW-1:0] nb_c;

    // pipeline: slot index -> partition read -> point read -> distance
    cell_ctl_t c0_reg, c1_reg, c2_reg;
    logic [PIDX_W-1:0] pidx_reg [2][MAX_BITS];
    logic signed [SW-1:0] pi_reg [2][MAX_BITS];
    logic signed [SW-1:0] pq_reg [2][MAX_BITS];
    logic [DW-1:0] dist_reg [2][MAX_BITS];

    logic signed [LLR_W-1:0] cell_llr [MAX_BITS];
    logic cell_done [MAX_BITS];
    logic signed [LLR_W-1:0] llr_hold [MAX_BITS];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        if (num_points_reg[6:1] == 6'd0)
            slots_c = CW'(1);
        else if ({1'b0, num_points_reg[6:1]} > 7'(HALF_POINTS))
            slots_c = CW'(HALF_POINTS);
        else
            slots_c = CW'(num_points_reg[6:1]);
        if (bits_reg == 3'd0)
            nb_c = BCW'(1);
        else if (4'(bits_reg) > 4'(MAX_BITS))
            nb_c = BCW'(MAX_BITS);
        else
            nb_c = BCW'(bits_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= 7'd4;
            bits_reg       <= 3'd2;
            inv_var_reg    <= 16'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_NUM_POINTS: num_points_reg <= cfg_data[6:0];
                REG_BITS:       bits_reg       <= cfg_data[2:0];
                REG_INV_VAR:    inv_var_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && opcode == OP_DEMAP)
        begin
            rxi_reg <= rx_i;
            rxq_reg <= rx_q;
        end
    end

    // sweep datapath
    generate
        for (genvar h = 0; h < 2; h++)
        begin : g_half
            for (genvar b = 0; b < MAX_BITS; b++)
            begin : g_bit
                logic signed [SW:0] di, dq;
                logic signed [2*SW+1:0] di2, dq2;
                // partition half for this bit, plus a private copy of the point
                // table so each lane reads a single address a cycle
                logic [PIDX_W-1:0] part_mem [HALF_POINTS];
                logic signed [SW-1:0] pi_mem [NPTS];
                logic signed [SW-1:0] pq_mem [NPTS];
                assign di  = $signed({rxi_reg[SW-1], rxi_reg})
                           - $signed({pi_reg[h][b][SW-1], pi_reg[h][b]});
                assign dq  = $signed({rxq_reg[SW-1], rxq_reg})
                           - $signed({pq_reg[h][b][SW-1], pq_reg[h][b]});
                assign di2 = di * di;
                assign dq2 = dq * dq;
                always_ff @(posedge clk)
                begin
                    if (accept && opcode == OP_LOAD_POINT)
                    begin
                        pi_mem[point_index] <= point_i;
                        pq_mem[point_index] <= point_q;
                    end
                    if (accept && opcode == OP_LOAD_PART && 32'(label_value) == h
                        && 32'(bit_position) == b && 32'(slot) < HALF_POINTS)
                        part_mem[SLW'(slot)] <= point_index;
                    pidx_reg[h][b] <= part_mem[cnt_reg[SLW-1:0]];
                    pi_reg[h][b]   <= pi_mem[pidx_reg[h][b]];
                    pq_reg[h][b]   <= pq_mem[pidx_reg[h][b]];
                    dist_reg[h][b] <= DW'($unsigned(di2)) + DW'($unsigned(dq2));
                end
            end
        end
        for (genvar b = 0; b < MAX_BITS; b++)
        begin : g_cell
            mld_cell #(.DW(DW)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (c2_reg),
                .dist0   (dist_reg[0][b]),
                .dist1   (dist_reg[1][b]),
                .inv_var (inv_var_reg),
                .done    (cell_done[b]),
                .llr     (cell_llr[b])
            );
            always_ff @(posedge clk)
            begin
                if (cell_done[b])
                    llr_hold[b] <= cell_llr[b];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            nslot_reg <= '0;
            nb_reg    <= '0;
            emit_reg  <= '0;
            last_reg  <= 1'b0;
            c0_reg    <= '0;
            c1_reg    <= '0;
            c2_reg    <= '0;
        end
        else
        begin
            c1_reg <= c0_reg;
            c2_reg <= c1_reg;
            c0_reg <= '0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && opcode == OP_DEMAP)
                    begin
                        state_reg <= ST_SWEEP;
                        cnt_reg   <= '0;
                        nslot_reg <= slots_c;
                        nb_reg    <= nb_c;
                        last_reg  <= last_symbol;
                    end
                end
                ST_SWEEP:
                begin
                    c0_reg.valid <= 1'b1;
                    c0_reg.first <= (cnt_reg == '0);
                    c0_reg.last  <= (cnt_reg == nslot_reg - CW'(1));
                    if (cnt_reg == nslot_reg - CW'(1))
                        state_reg <= ST_DRAIN;
                    else
                        cnt_reg <= cnt_reg + CW'(1);
                end
                ST_DRAIN:
                begin
                    if (cell_done[0])
                    begin
                        state_reg <= ST_EMIT;
                        emit_reg  <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_stall)
                    begin
                        if (emit_reg == nb_reg - BCW'(1))
                            state_reg <= ST_IDLE;
                        else
                            emit_reg <= emit_reg + BCW'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid      = (state_reg == ST_EMIT);
    assign llr            = llr_hold[emit_reg[BW-1:0]];
    assign bit_index      = 3'(emit_reg);
    assign last_of_symbol = (emit_reg == nb_reg - BCW'(1));
    assign last_of_block  = last_of_symbol && last_reg;

endmodule

`default_nettype wire

/* src/mld_cell.sv */
// ----------------------------------------------------------------------------
// mld_cell
// One cell per label bit: running minimum over both halves of its partition,
// then scale and saturate into an LLR once the slot sweep is done.
// ----------------------------------------------------------------------------
`default_nettype none

module mld_cell #(
    parameter int DW = 2 * mld_pkg::SAMPLE_WIDTH_DEF + 2
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  mld_pkg::cell_ctl_t            ctl,
    input  wire logic [DW-1:0]            dist0,
    input  wire logic [DW-1:0]            dist1,
    input  wire logic [15:0]              inv_var,
    output logic                          done,
    output logic signed [mld_pkg::LLR_W-1:0] llr
);
    import mld_pkg::*;

    localparam int DFW = DW + 1;
    localparam int PW  = DFW + 17;

    logic [DW-1:0]          min0_reg, min0_next;
    logic [DW-1:0]          min1_reg, min1_next;
    logic                   fin_reg, mul_reg, prd_reg, done_reg;
    logic signed [DFW-1:0]  diff_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   rnd;
    logic signed [PW-1:0]   shf;
    logic signed [LLR_W-1:0] llr_reg;

    always_comb
    begin
        min0_next = min0_reg;
        min1_next = min1_reg;
        if (ctl.valid)
        begin
            if (ctl.first || dist0 < min0_reg)
                min0_next = dist0;
            if (ctl.first || dist1 < min1_reg)
                min1_next = dist1;
        end
    end

    // round half up, floor shift, saturate
    assign rnd = prod_reg + (PW)'(1 << (OUT_SHIFT - 1));
    assign shf = rnd >>> OUT_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg  <= 1'b0;
            mul_reg  <= 1'b0;
            prd_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            fin_reg  <= ctl.valid & ctl.last;
            mul_reg  <= fin_reg;
            prd_reg  <= mul_reg;
            done_reg <= prd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        min0_reg <= min0_next;
        min1_reg <= min1_next;
        diff_reg <= $signed({1'b0, min0_reg}) - $signed({1'b0, min1_reg});
        prod_reg <= PW'(diff_reg) * $signed({1'b0, inv_var});
        if (shf > PW'(2 ** (LLR_W - 1) - 1))
            llr_reg <= {1'b0, {(LLR_W-1){1'b1}}};
        else if (shf < -PW'(2 ** (LLR_W - 1)))
            llr_reg <= {1'b1, {(LLR_W-1){1'b0}}};
        else
            llr_reg <= shf[LLR_W-1:0];
    end

    assign done = done_reg;
    assign llr  = llr_reg;

endmodule

`default_nettype wire
